// File: rtl/bms_serial_frame_finder_defines.svh
// Assertion macros shared by the frame finder modules.
`ifndef BMS_SERIAL_FRAME_FINDER_DEFINES_SVH
`define BMS_SERIAL_FRAME_FINDER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BSFF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame finder check failed");

// Next-cycle implication, disabled during reset.
`define BSFF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame finder check failed");

`endif

// File: rtl/bsff_pkg.sv
// Shared constants and result type for the serial frame finder.
package bsff_pkg;

  localparam logic [7:0] START_BYTE = 8'hDD;
  localparam logic [7:0] END_BYTE   = 8'h77;
  localparam int unsigned MIN_FRAME = 7;
  localparam int unsigned OFF_W     = 9;
  localparam int unsigned LEN_W     = 9;
  localparam int unsigned SUM_W     = 16;

  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] frame_offset;
    logic [LEN_W-1:0] frame_length;
    logic             truncated;
  } scan_result_t;

endpackage

// File: rtl/bsff_byte_buf.sv
// Byte buffer memory: one write port, one registered read port.
module bsff_byte_buf #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/bsff_scan_seq.sv
// Scan sequencer: walks the buffer through one read port.
`include "bms_serial_frame_finder_defines.svh"

module bsff_scan_seq #(
  parameter int unsigned AW        = 9,
  parameter int unsigned CW        = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic [CW-1:0]         go_count,
  input  logic                  go_overflow,
  input  logic [7:0]            match_cmd,
  output logic [AW-1:0]         rd_addr,
  input  logic [7:0]            rd_data,
  output logic                  scan_busy,
  output logic                  done,
  output bsff_pkg::scan_result_t result
);

  localparam int unsigned PW = ((CW > bsff_pkg::LEN_W) ? CW : bsff_pkg::LEN_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_FIRST, S_HEAD, S_CMD, S_LEN, S_TAIL, S_SUM, S_CKH, S_CKL
  } state_t;

  state_t                       state, state_next;
  logic [PW-1:0]                cnt, cnt_next;
  logic                         ovf, ovf_next;
  logic [PW-1:0]                base, base_next;
  logic [PW-1:0]                cur, cur_next;
  logic [PW-1:0]                sum_end, sum_end_next;
  logic [bsff_pkg::LEN_W-1:0]   total, total_next;
  logic [bsff_pkg::SUM_W-1:0]   acc, acc_next;
  logic [7:0]                   ck_hi, ck_hi_next;
  logic                         done_next;
  bsff_pkg::scan_result_t       result_next;
  logic [PW-1:0]                addr_next;

  logic [PW-1:0]                adv_base;
  logic                         adv_end;
  logic [PW-1:0]                left;
  logic [bsff_pkg::LEN_W-1:0]   len_total;
  logic [bsff_pkg::SUM_W-1:0]   got;
  logic [bsff_pkg::SUM_W-1:0]   neg_plain;
  logic [bsff_pkg::SUM_W-1:0]   neg_cmd;

  assign adv_base  = base + PW'(1);
  assign adv_end   = (adv_base >= cnt);
  assign left      = cnt - base;
  assign len_total = bsff_pkg::LEN_W'(rd_data) + bsff_pkg::LEN_W'(bsff_pkg::MIN_FRAME);
  assign got       = {ck_hi, rd_data};
  assign neg_plain = '0 - acc;
  assign neg_cmd   = '0 - (acc + bsff_pkg::SUM_W'(match_cmd));

  assign rd_addr   = addr_next[AW-1:0];
  assign scan_busy = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    ovf_next     = ovf;
    base_next    = base;
    cur_next     = cur;
    sum_end_next = sum_end;
    total_next   = total;
    acc_next     = acc;
    ck_hi_next   = ck_hi;
    done_next    = 1'b0;
    result_next  = result;
    addr_next    = '0;

    unique case (state)
      S_IDLE: begin
        if (go) begin
          cnt_next   = PW'(go_count);
          ovf_next   = go_overflow;
          base_next  = '0;
          state_next = S_FIRST;
        end
      end
      // wait state so the last byte's write lands before the first read
      S_FIRST: begin
        addr_next  = base;
        state_next = S_HEAD;
      end
      S_HEAD: begin
        if (rd_data != bsff_pkg::START_BYTE) begin
          base_next = adv_base;
          if (adv_end) begin
            state_next = S_IDLE;
            done_next  = 1'b1;
            result_next = '{found: 1'b0, frame_offset: '0, frame_length: '0,
                            truncated: ovf};
          end else begin
            addr_next  = adv_base;
          end
        end else if (left < PW'(bsff_pkg::MIN_FRAME)) begin
          state_next  = S_IDLE;
          done_next   = 1'b1;
          result_next = '{found: 1'b0, frame_offset: '0, frame_length: '0,
                          truncated: ovf};
        end else begin
          addr_next  = base + PW'(1);
          state_next = S_CMD;
        end
      end
      S_CMD: begin
        if (rd_data != match_cmd) begin
          base_next = adv_base;
          if (adv_end) begin
            state_next  = S_IDLE;
            done_next   = 1'b1;
            result_next = '{found: 1'b0, frame_offset: '0, frame_length: '0,
                            truncated: ovf};
          end else begin
            addr_next  = adv_base;
            state_next = S_HEAD;
          end
        end else begin
          addr_next  = base + PW'(3);
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        total_next   = len_total;
        sum_end_next = base + PW'(rd_data) + PW'(3);
        if (left < PW'(len_total)) begin
          state_next  = S_IDLE;
          done_next   = 1'b1;
          result_next = '{found: 1'b0, frame_offset: '0, frame_length: '0,
                          truncated: ovf};
        end else begin
          addr_next  = base + PW'(len_total) - PW'(1);
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        if (rd_data != bsff_pkg::END_BYTE) begin
          base_next = adv_base;
          if (adv_end) begin
            state_next  = S_IDLE;
            done_next   = 1'b1;
            result_next = '{found: 1'b0, frame_offset: '0, frame_length: '0,
                            truncated: ovf};
          end else begin
            addr_next  = adv_base;
            state_next = S_HEAD;
          end
        end else begin
          acc_next   = '0;
          cur_next   = base + PW'(2);
          addr_next  = base + PW'(2);
          state_next = S_SUM;
        end
      end
      // accumulate status, length and payload; cur ends on the checksum high byte
      S_SUM: begin
        acc_next  = acc + bsff_pkg::SUM_W'(rd_data);
        cur_next  = cur + PW'(1);
        addr_next = cur + PW'(1);
        if (cur == sum_end) begin
          state_next = S_CKH;
        end
      end
      S_CKH: begin
        ck_hi_next = rd_data;
        addr_next  = cur + PW'(1);
        state_next = S_CKL;
      end
      S_CKL: begin
        if (got == neg_plain || got == neg_cmd) begin
          state_next  = S_IDLE;
          done_next   = 1'b1;
          result_next = '{found: 1'b1, frame_offset: base[bsff_pkg::OFF_W-1:0],
                          frame_length: total, truncated: ovf};
        end else begin
          base_next = adv_base;
          if (adv_end) begin
            state_next  = S_IDLE;
            done_next   = 1'b1;
            result_next = '{found: 1'b0, frame_offset: '0, frame_length: '0,
                            truncated: ovf};
          end else begin
            addr_next  = adv_base;
            state_next = S_HEAD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      result <= '0;
    end else begin
      state  <= state_next;
      done   <= done_next;
      result <= result_next;
    end
    cnt     <= cnt_next;
    ovf     <= ovf_next;
    base    <= base_next;
    cur     <= cur_next;
    sum_end <= sum_end_next;
    total   <= total_next;
    acc     <= acc_next;
    ck_hi   <= ck_hi_next;
  end

  `BSFF_ASSERT_NEXT(a_go_leaves_idle, clk, rst, go && state == S_IDLE, state == S_FIRST)
  `BSFF_ASSERT_NOW(a_found_len_min, clk, rst, done && result.found,
                   result.frame_length >= bsff_pkg::LEN_W'(bsff_pkg::MIN_FRAME))
  `BSFF_ASSERT_NOW(a_miss_zero, clk, rst, done && !result.found,
                   result.frame_offset == '0 && result.frame_length == '0)

endmodule

// File: rtl/bms_serial_frame_finder.sv
// Top level: byte loading, command register and frame scan.
//
//  channel   dir  handshake            payload
//  input     in   start / busy         byte_value, last_byte
//  result    out  done (1-cycle)       found, frame_offset, frame_length, truncated
//  config    in   cfg_wr_en            cfg_wr_data (command byte to match)
//
// A byte that is not last is taken while busy is low, and busy stays low.
// A last byte starts a scan through the buffer's single read port: a setup
// state, a check of each position for a start byte, then for each start-byte
// candidate the command, length and end byte, and a checksum pass over its
// status, length, payload and checksum bytes. done rises as busy falls.
// Reset clears the byte count, the overflow flag and the command to 3.
// The result cannot be stalled; the next byte may be taken in the done cycle.
`include "bms_serial_frame_finder_defines.svh"

module bms_serial_frame_finder #(
  parameter int unsigned BUF_DEPTH = 512
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [7:0]                 byte_value,
  input  logic                       last_byte,
  input  logic                       cfg_wr_en,
  input  logic [7:0]                 cfg_wr_data,
  output logic                       done,
  output logic                       found,
  output logic [bsff_pkg::OFF_W-1:0] frame_offset,
  output logic [bsff_pkg::LEN_W-1:0] frame_length,
  output logic                       truncated
);

  localparam int unsigned AW = $clog2(BUF_DEPTH);
  localparam int unsigned CW = $clog2(BUF_DEPTH + 1);

  logic [CW-1:0]          byte_count, byte_count_next;
  logic                   overflow_seen, overflow_seen_next;
  logic [7:0]             match_cmd;
  logic                   accept;
  logic                   has_room;
  logic                   go;
  logic [AW-1:0]          rd_addr;
  logic [7:0]             rd_data;
  logic                   scan_busy;
  bsff_pkg::scan_result_t result;

  assign accept   = start && !busy;
  assign has_room = (byte_count < CW'(BUF_DEPTH));
  assign go       = accept && last_byte;
  assign busy     = scan_busy;

  always_comb begin
    byte_count_next    = byte_count;
    overflow_seen_next = overflow_seen;
    if (accept) begin
      if (has_room) begin
        byte_count_next = byte_count + CW'(1);
      end else begin
        overflow_seen_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= '0;
      overflow_seen    <= 1'b0;
      match_cmd        <= 8'd3;
    end else begin
      // hand the totals to the scanner and empty the buffer
      if (go) begin
        byte_count    <= '0;
        overflow_seen <= 1'b0;
      end else begin
        byte_count    <= byte_count_next;
        overflow_seen <= overflow_seen_next;
      end
      if (cfg_wr_en) begin
        match_cmd <= cfg_wr_data;
      end
    end
  end

  bsff_byte_buf #(
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_buf (
    .clk     (clk),
    .wr_en   (accept && has_room),
    .wr_addr (byte_count[AW-1:0]),
    .wr_data (byte_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bsff_scan_seq #(
    .AW        (AW),
    .CW        (CW)
  ) u_scan (
    .clk              (clk),
    .rst              (rst),
    .go               (go),
    .go_count         (byte_count_next),
    .go_overflow      (overflow_seen_next),
    .match_cmd        (match_cmd),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .scan_busy        (scan_busy),
    .done             (done),
    .result           (result)
  );

  assign found        = result.found;
  assign frame_offset = result.frame_offset;
  assign frame_length = result.frame_length;
  assign truncated    = result.truncated;

  `BSFF_ASSERT_NEXT(a_last_sets_busy, clk, rst, go, busy && byte_count == '0)
  `BSFF_ASSERT_NOW(a_done_empty, clk, rst, done, byte_count == '0 && !overflow_seen)
  `BSFF_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, byte_count <= CW'(BUF_DEPTH))

endmodule

// File: sim/bms_serial_frame_finder_tb.sv
// Self-checking testbench for the serial frame finder: loading, scan results, command.
module bms_serial_frame_finder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BUF_DEPTH     = 512;
  localparam int unsigned PHASE_BYTES   = 140;
  localparam int unsigned SETTLE_CYCLES = 8;
  // Stall limit, sized for a full buffer whose every position runs a full checksum
  // pass over a 255-byte payload; counts cycles with nothing accepted and no result.
  localparam int unsigned STALL_LIMIT   = 600_000;

  typedef enum int unsigned {
    FLAW_NONE,
    FLAW_CMD,
    FLAW_END,
    FLAW_SUM,
    FLAW_CUT
  } frame_flaw_t;

  class frame_scan_checker;
    logic [7:0]             mem [BUF_DEPTH];
    int unsigned            fill;
    bit                     dropped;
    logic [7:0]             cmd;
    bsff_pkg::scan_result_t scans_due [$];
    int unsigned            fails;

    function new();
      fill    = 0;
      dropped = 1'b0;
      cmd     = 8'h03;
      fails   = 0;
    endfunction

    function int unsigned pending();
      return scans_due.size();
    endfunction

    function logic [15:0] checksum_of(int unsigned first, int unsigned n);
      logic [15:0] acc;
      acc = '0;
      for (int unsigned k = 0; k < n; k++) acc += 16'(mem[first + k]);
      return 16'(0) - acc;
    endfunction

    function bit find_frame(output int unsigned off, output int unsigned len);
      int unsigned left;
      int unsigned n;
      int unsigned total;
      logic [15:0] got;
      off = 0;
      len = 0;
      for (int unsigned i = 0; i < fill; i++) begin
        if (mem[i] != bsff_pkg::START_BYTE) continue;
        left = fill - i;
        if (left < bsff_pkg::MIN_FRAME) return 1'b0;
        if (mem[i + 1] != cmd) continue;
        n = mem[i + 3];
        total = n + bsff_pkg::MIN_FRAME;
        if (left < total) return 1'b0;
        if (mem[i + total - 1] != bsff_pkg::END_BYTE) continue;
        got = {mem[i + 4 + n], mem[i + 5 + n]};
        // accept the sum with or without the command byte
        if (got != checksum_of(i + 2, n + 2) && got != checksum_of(i + 1, n + 3)) continue;
        off = i;
        len = total;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void take_byte(logic [7:0] value, logic last);
      bsff_pkg::scan_result_t r;
      int unsigned off;
      int unsigned len;
      if (fill < BUF_DEPTH) begin
        mem[fill] = value;
        fill++;
      end else begin
        dropped = 1'b1;
      end
      if (!last) return;
      r.found        = find_frame(off, len);
      r.frame_offset = r.found ? bsff_pkg::OFF_W'(off) : '0;
      r.frame_length = r.found ? bsff_pkg::LEN_W'(len) : '0;
      r.truncated    = dropped;
      scans_due.push_back(r);
      fill    = 0;
      dropped = 1'b0;
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        fails++;
      end
    endfunction

    function void check_scan(bsff_pkg::scan_result_t got);
      bsff_pkg::scan_result_t want;
      if (scans_due.size() == 0) begin
        $error("scan result with no last-byte transaction waiting");
        fails++;
        return;
      end
      want = scans_due.pop_front();
      compare_field("found", 16'(want.found), 16'(got.found));
      compare_field("frame_offset", 16'(want.frame_offset), 16'(got.frame_offset));
      compare_field("frame_length", 16'(want.frame_length), 16'(got.frame_length));
      compare_field("truncated", 16'(want.truncated), 16'(got.truncated));
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic [7:0]                 byte_value = '0;
  logic                       last_byte = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic [7:0]                 cfg_wr_data = '0;
  logic                       done;
  logic                       found;
  logic [bsff_pkg::OFF_W-1:0] frame_offset;
  logic [bsff_pkg::LEN_W-1:0] frame_length;
  logic                       truncated;

  frame_scan_checker sb = new();
  logic [7:0]        pending_bytes [$];
  int unsigned       sent_bytes = 0;
  int unsigned       stall_cycles = 0;

  bms_serial_frame_finder #(.BUF_DEPTH(BUF_DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .byte_value   (byte_value),
    .last_byte    (last_byte),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .done         (done),
    .found        (found),
    .frame_offset (frame_offset),
    .frame_length (frame_length),
    .truncated    (truncated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        sb.check_scan(bsff_pkg::scan_result_t'{found, frame_offset, frame_length, truncated});
      end
      if (start && !busy) sb.take_byte(byte_value, last_byte);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void push_noise(input int unsigned count);
    logic [7:0] data;
    repeat (count) begin
      data = 8'($urandom);
      // keep stray start bytes rare so most buffers reach their frames
      if (data == bsff_pkg::START_BYTE && $urandom_range(0, 9) != 0) data = ~data;
      pending_bytes.push_back(data);
    end
  endfunction

  function automatic void push_frame(input logic [7:0] command, input int unsigned n,
                                     input frame_flaw_t flaw, input bit cmd_in_sum,
                                     input logic [7:0] status);
    logic [15:0] sum;
    logic [15:0] check;
    logic [7:0]  data;
    sum = 16'(status) + 16'(n);
    pending_bytes.push_back(bsff_pkg::START_BYTE);
    pending_bytes.push_back(flaw == FLAW_CMD ? command ^ 8'($urandom_range(1, 255)) : command);
    pending_bytes.push_back(status);
    pending_bytes.push_back(8'(n));
    for (int unsigned k = 0; k < n; k++) begin
      data = 8'($urandom);
      sum += 16'(data);
      pending_bytes.push_back(data);
    end
    if (cmd_in_sum) sum += 16'(command);
    check = 16'(0) - sum;
    if (flaw == FLAW_SUM) check ^= 16'($urandom_range(1, 65535));
    pending_bytes.push_back(check[15:8]);
    pending_bytes.push_back(check[7:0]);
    if (flaw == FLAW_CUT) begin
      // drop the tail, up to the whole frame, so the buffer ends inside or before the frame
      repeat ($urandom_range(1, n + 6)) void'(pending_bytes.pop_back());
    end else begin
      pending_bytes.push_back(flaw == FLAW_END
                              ? bsff_pkg::END_BYTE ^ 8'($urandom_range(1, 255))
                              : bsff_pkg::END_BYTE);
    end
  endfunction

  function automatic int unsigned random_payload_len();
    return ($urandom_range(0, 11) == 0) ? $urandom_range(21, 80) : $urandom_range(0, 20);
  endfunction

  task automatic send_byte(input logic [7:0] value, input logic last);
    start      <= 1'b1;
    byte_value <= value;
    last_byte  <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_buffer(input int unsigned idle_pct);
    int unsigned count;
    count = pending_bytes.size();
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      send_byte(pending_bytes[i], i == count - 1);
    end
    sent_bytes += count;
    pending_bytes.delete();
  endtask

  task automatic drain(input int unsigned settle);
    start <= 1'b0;
    // first let the monitor log the last transaction, then wait for no pending scan
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_command(input logic [7:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.cmd = value;
  endtask

  task automatic run_phase(input int unsigned phase);
    int unsigned idle_pct;
    int unsigned stop_at;
    int unsigned pick;
    frame_flaw_t flaw;
    idle_pct = (phase < 2) ? 16 : ((phase < 4) ? 49 : 0);
    stop_at  = sent_bytes + PHASE_BYTES;
    if (phase == 1) begin
      // fill the buffer exactly with a frame at the last possible offset, then overflow
      push_noise(BUF_DEPTH - bsff_pkg::MIN_FRAME);
      push_frame(sb.cmd, 0, FLAW_NONE, 1'b0, 8'($urandom));
      push_noise($urandom_range(1, 4));
      send_buffer(idle_pct);
    end
    if (phase == 2) begin
      push_noise($urandom_range(0, 2));
      push_frame(sb.cmd, 255, FLAW_NONE, 1'($urandom), 8'($urandom));
      send_buffer(idle_pct);
    end
    while (sent_bytes < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        flaw = ($urandom_range(0, 99) < 70) ? FLAW_NONE
                                            : frame_flaw_t'($urandom_range(FLAW_CMD, FLAW_CUT));
        push_noise($urandom_range(0, 6));
        push_frame(sb.cmd, random_payload_len(), flaw, 1'($urandom), 8'($urandom));
        if (flaw != FLAW_CUT) push_noise($urandom_range(0, 4));
      end else if (pick < 80) begin
        // broken frame ahead of a good one: the scan must move past it
        push_noise($urandom_range(0, 3));
        push_frame(sb.cmd, random_payload_len(),
                   frame_flaw_t'($urandom_range(FLAW_CMD, FLAW_SUM)),
                   1'($urandom), 8'($urandom));
        push_noise($urandom_range(0, 2));
        push_frame(sb.cmd, random_payload_len(), FLAW_NONE, 1'($urandom), 8'($urandom));
        push_noise($urandom_range(0, 2));
      end else begin
        push_noise($urandom_range(1, 16));
      end
      send_buffer(idle_pct);
      if ($urandom_range(0, 7) == 0) drain(0);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed buffers under the reset command
    pending_bytes.push_back(8'hFF);
    send_buffer(0);
    push_frame(8'h03, 0, FLAW_NONE, 1'b0, 8'h00);
    send_buffer(0);
    push_frame(8'h03, 0, FLAW_NONE, 1'b1, 8'hFF);
    send_buffer(0);
    pending_bytes.push_back(bsff_pkg::START_BYTE);
    pending_bytes.push_back(8'h03);
    pending_bytes.push_back(8'h00);
    send_buffer(0);

    for (int unsigned phase = 0; phase < 6; phase++) begin
      drain(SETTLE_CYCLES);
      case (phase)
        0: write_command(8'h00);
        1: write_command(8'hFF);
        2: write_command(bsff_pkg::START_BYTE);
        3: write_command(bsff_pkg::END_BYTE);
        4: write_command(8'($urandom));
        default: write_command(8'h03);
      endcase
      run_phase(phase);
    end

    drain(SETTLE_CYCLES);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/bsff_pkg.sv
rtl/bsff_byte_buf.sv
rtl/bsff_scan_seq.sv
rtl/bms_serial_frame_finder.sv
sim/bms_serial_frame_finder_tb.sv
